[rtl/core/lir_pkg.sv]
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

   localparam int IO_CH       = 2;
   localparam int SAMPLE_W    = 16;
   localparam int STEP_W      = 20;
   localparam int ACT_W       = 2;
   localparam int RESULT_CAP  = 64;
   localparam int COUNT_W     = $clog2(RESULT_CAP);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = STEP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANNELS = 1'b1;

   localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
   localparam logic [ACT_W-1:0]  ACT_RESET  = 2'd2;

   typedef struct packed {
      logic                               prime;
      logic [IO_CH-1:0][SAMPLE_W-1:0]     sample;
   } lir_item_type;

   typedef struct packed {
      logic               emit;
      logic [COUNT_W-1:0] run_count;
   } lir_back_status_type;

endpackage

[rtl/core/lir_front.sv]
// Front end: accepts input frames and tags the priming frame.
module lir_front
   import lir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample_ch0,
   input  logic [SAMPLE_W-1:0] req_sample_ch1,
   input  logic                queue_full,
   output logic                push,
   output lir_item_type        push_item
);

   logic have_prev_ff;
   logic have_prev_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_item.prime     = !have_prev_ff;
      push_item.sample[0] = req_sample_ch0;
      push_item.sample[1] = req_sample_ch1;
      have_prev_in        = have_prev_ff || push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

[rtl/core/lir_queue.sv]
// Short FIFO between the front end and the interpolation engine.
module lir_queue
   import lir_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lir_item_type push_item,
   output logic         full,
   output logic         head_valid,
   output lir_item_type head_item,
   input  logic         pop
);

   lir_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/lir_back.sv]
// Interpolation engine: walks the read phase and emits one result per cycle while the output register is free.
module lir_back
   import lir_pkg::*;
#(
   parameter int PFB      = 16,
   parameter int STORE_CH = 2
)(
   input  logic                clock,
   input  logic                reset,
   input  logic [STEP_W-1:0]   step_size,
   input  logic [ACT_W-1:0]    active_channels,
   input  logic                head_valid,
   input  lir_item_type        head_item,
   output logic                pop,
   output lir_back_status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_out_ch0,
   output logic [SAMPLE_W-1:0] rsp_out_ch1,
   output logic                rsp_last_of_run
);

   localparam int PW = ((PFB + 1 > STEP_W) ? PFB + 1 : STEP_W) + 1;
   localparam logic [PW-1:0] ONE = PW'(1) << PFB;

   logic [PW-1:0]       phase_ff, phase_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                last_ff;
   logic [SAMPLE_W-1:0] ch_ff  [IO_CH];
   logic [SAMPLE_W-1:0] ch_val [IO_CH];
   logic [PW-1:0]       next_phase;
   logic [ACT_W-1:0]    nact;
   logic                head_run;
   logic                in_range;
   logic                slot_free;
   logic                emit;
   logic                last;

   always_comb begin
      if (active_channels == '0) begin
         nact = ACT_W'(1);
      end else if (active_channels > ACT_W'(STORE_CH)) begin
         nact = ACT_W'(STORE_CH);
      end else begin
         nact = active_channels;
      end
   end

   always_comb begin
      head_run   = head_valid && !head_item.prime;
      in_range   = (phase_ff < ONE);
      slot_free  = !rsp_valid_ff || rsp_ready;
      emit       = head_run && in_range && slot_free;
      next_phase = phase_ff + PW'(step_size);
      last       = (next_phase >= ONE) || (count_ff == COUNT_W'(RESULT_CAP - 1));
      pop        = head_valid && (head_item.prime || !in_range || (emit && last));

      phase_in = phase_ff;
      count_in = count_ff;
      if (emit) begin
         if (last) begin
            phase_in = (next_phase >= ONE) ? next_phase - ONE : '0;
            count_in = '0;
         end else begin
            phase_in = next_phase;
            count_in = count_ff + 1'b1;
         end
      end else if (head_run && !in_range) begin
         phase_in = phase_ff - ONE;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   for (genvar c = 0; c < IO_CH; c++) begin : g_ch
      if (c < STORE_CH) begin : g_store
         logic [SAMPLE_W-1:0]            prev_ff;
         logic signed [SAMPLE_W:0]       diff;
         logic signed [PFB:0]            frac;
         logic signed [SAMPLE_W+PFB+1:0] prod;
         logic signed [SAMPLE_W+PFB+1:0] shifted;
         logic [SAMPLE_W-1:0]            interp;

         always_comb begin
            diff    = $signed({head_item.sample[c][SAMPLE_W-1], head_item.sample[c]})
                    - $signed({prev_ff[SAMPLE_W-1], prev_ff});
            frac    = $signed({1'b0, phase_ff[PFB-1:0]});
            prod    = diff * frac;
            // arithmetic shift floors toward minus infinity
            shifted = prod >>> PFB;
            interp  = prev_ff + shifted[SAMPLE_W-1:0];
            ch_val[c] = (ACT_W'(c) < nact) ? interp : '0;
         end

         always_ff @(posedge clock) begin
            if (pop) begin
               prev_ff <= head_item.sample[c];
            end
         end
      end else begin : g_none
         assign ch_val[c] = '0;
      end

      always_ff @(posedge clock) begin
         if (emit) begin
            ch_ff[c] <= ch_val[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         last_ff <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_ch0      = ch_ff[0];
   assign rsp_out_ch1      = ch_ff[1];
   assign rsp_last_of_run  = last_ff;
   assign status.emit      = emit;
   assign status.run_count = count_ff;

endmodule

[rtl/core/linear_interp_resampler.sv]
// Top level of the linear interpolation sample-rate converter.
//
// Input frames arrive on req_* (valid/ready), one signed Q1.15 sample per
// channel. Results leave on rsp_* (valid/ready); rsp_last_of_run marks the
// final result caused by a frame. csr_* writes step_size (index 0, Q4.16)
// and active_channels (index 1); csr_ready is always high and writes are
// meant for an idle block.
// A two-entry queue sits between the input side and the interpolation
// engine, so frames keep being taken while the engine runs or the
// receiver stalls; req_ready drops only when the queue is full.
// When the block is idle, the first result of a frame passes through the
// queue entry and the output register before it is on rsp_*.
// The engine produces one result per cycle while the output register is
// free; a frame gives 0 to 64 results, and a priming frame or one with no
// results is popped without a result.
// Reset clears the phase, the priming flag and the queue and loads the
// register defaults. A stalled receiver holds the output register and
// the engine waits on it.
module linear_interp_resampler
   import lir_pkg::*;
#(
   parameter int MAX_CHANNELS        = 2,
   parameter int PHASE_FRACTION_BITS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample_ch0,
   input  logic [SAMPLE_W-1:0]   req_sample_ch1,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]   rsp_out_ch0,
   output logic [SAMPLE_W-1:0]   rsp_out_ch1,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int STORE_CH = (MAX_CHANNELS < IO_CH) ? MAX_CHANNELS : IO_CH;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ACT_W-1:0]    act_ff, act_in;
   logic                q_push;
   lir_item_type        q_push_item;
   logic                q_full;
   logic                q_valid;
   lir_item_type        q_item;
   logic                q_pop;
   lir_back_status_type back_status;

   assign csr_ready = 1'b1;

   always_comb begin
      step_in = step_ff;
      act_in  = act_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_SIZE:       step_in = csr_wdata[STEP_W-1:0];
            CSR_ACTIVE_CHANNELS: act_in  = csr_wdata[ACT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         act_ff  <= ACT_RESET;
      end else begin
         step_ff <= step_in;
         act_ff  <= act_in;
      end
   end

   lir_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_ch0 (req_sample_ch0),
      .req_sample_ch1 (req_sample_ch1),
      .queue_full     (q_full),
      .push           (q_push),
      .push_item      (q_push_item)
   );

   lir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (q_item),
      .pop        (q_pop)
   );

   lir_back #(
      .PFB      (PHASE_FRACTION_BITS),
      .STORE_CH (STORE_CH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .step_size       (step_ff),
      .active_channels (act_ff),
      .head_valid      (q_valid),
      .head_item       (q_item),
      .pop             (q_pop),
      .status          (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_ch0     (rsp_out_ch0),
      .rsp_out_ch1     (rsp_out_ch1),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("input stalled with empty queue");

   a_prime_no_result: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_item.prime) |-> !back_status.emit)
      else $error("result emitted for priming frame");

   a_cap_ends_run: assert property (@(posedge clock) disable iff (reset)
      (back_status.emit && back_status.run_count == COUNT_W'(RESULT_CAP - 1))
      |=> (rsp_valid && rsp_last_of_run))
      else $error("run not closed at result cap");

endmodule

[tb/sv/linear_interp_resampler_tb.sv]
// Testbench for linear_interp_resampler: directed table, then random frames checked by a predictor.
`timescale 1ns / 100ps

module linear_interp_resampler_tb;
   import lir_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int UNIT_PHASE    = 1 << 16;
   localparam int BLOCKS        = 9;
   localparam int FRAMES_PER_BLOCK = 20;
   localparam int ROWS          = 21;

   typedef enum logic [1:0] {ROW_WRITE, ROW_FRAME, ROW_FRAME_LIT} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      logic [SAMPLE_W-1:0]    a;
      logic [SAMPLE_W-1:0]    b;
      logic                   lit_hit;
      logic [SAMPLE_W-1:0]    e0;
      logic [SAMPLE_W-1:0]    e1;
   } row_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] ch0;
      logic [SAMPLE_W-1:0] ch1;
      logic                last;
   } interp_out_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample_ch0 = '0;
   logic [SAMPLE_W-1:0]   req_sample_ch1 = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_out_ch0;
   logic [SAMPLE_W-1:0]   rsp_out_ch1;
   logic                  rsp_last_of_run;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // predictor state
   logic [STEP_W-1:0] step_reg  = STEP_RESET;
   logic [ACT_W-1:0]  act_reg   = ACT_RESET;
   bit                primed    = 1'b0;
   int                prev_smp [IO_CH] = '{0, 0};
   int unsigned       phase_acc = 0;

   interp_out_type frame_outs [$];
   interp_out_type due_samples [$];
   interp_out_type got;
   bit             steady     = 1'b0;
   int             fail_count = 0;
   int             idle_run   = 0;

   // interpolation term is floored, so arithmetic shift
   row_type plan [ROWS] = '{
      '{ROW_FRAME_LIT, CSR_STEP_SIZE, 20'd0, 16'd100, -16'sd200, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME_LIT, CSR_STEP_SIZE, 20'd0, 16'h7FFF, 16'h8000, 1'b1, 16'd100, -16'sd200},
      '{ROW_FRAME_LIT, CSR_STEP_SIZE, 20'd0, 16'h8000, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000},
      '{ROW_FRAME_LIT, CSR_STEP_SIZE, 20'd0, 16'h0000, 16'h0000, 1'b1, 16'h8000, 16'h7FFF},
      '{ROW_WRITE, CSR_STEP_SIZE, 20'd32768, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0},
      '{ROW_WRITE, CSR_ACTIVE_CHANNELS, 20'd1, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'd1234, -16'sd5678, 1'b0, 16'd0, 16'd0},
      '{ROW_WRITE, CSR_ACTIVE_CHANNELS, 20'd0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'hFFFF, 16'd1, 1'b0, 16'd0, 16'd0},
      '{ROW_WRITE, CSR_ACTIVE_CHANNELS, 20'd3, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'h8000, 16'hFFFF, 1'b0, 16'd0, 16'd0},
      // 64-result cap reached with phase still below one
      '{ROW_WRITE, CSR_STEP_SIZE, 20'd1000, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'h7FFF, 16'h7FFF, 1'b0, 16'd0, 16'd0},
      '{ROW_WRITE, CSR_STEP_SIZE, 20'hFFFFF, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'h8000, 16'h0000, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME_LIT, CSR_STEP_SIZE, 20'd0, 16'd5, 16'd6, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME_LIT, CSR_STEP_SIZE, 20'd0, 16'd7, 16'd8, 1'b0, 16'd0, 16'd0},
      '{ROW_WRITE, CSR_STEP_SIZE, 20'd1024, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
      '{ROW_FRAME, CSR_STEP_SIZE, 20'd0, 16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0}
   };

   linear_interp_resampler dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_ch0  (req_sample_ch0),
      .req_sample_ch1  (req_sample_ch1),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_ch0     (rsp_out_ch0),
      .rsp_out_ch1     (rsp_out_ch1),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [SAMPLE_W-1:0] blend(input int prev, input int cur,
                                                 input int unsigned frac);
      longint prod;
      prod = longint'(cur - prev) * longint'(frac);
      return SAMPLE_W'(prev + int'(prod >>> 16));
   endfunction

   function automatic void resample_frame(input logic [SAMPLE_W-1:0] s0,
                                          input logic [SAMPLE_W-1:0] s1);
      int             cur [IO_CH];
      int             nact;
      int unsigned    ph;
      interp_out_type r;
      cur[0] = int'($signed(s0));
      cur[1] = int'($signed(s1));
      frame_outs.delete();
      nact = (act_reg == 0) ? 1 : ((act_reg > IO_CH) ? IO_CH : int'(act_reg));
      if (!primed) begin
         prev_smp = cur;
         primed = 1'b1;
         return;
      end
      ph = phase_acc;
      while (ph < UNIT_PHASE && frame_outs.size() < RESULT_CAP) begin
         r.ch0  = blend(prev_smp[0], cur[0], ph);
         r.ch1  = (nact > 1) ? blend(prev_smp[1], cur[1], ph) : '0;
         r.last = 1'b0;
         frame_outs.push_back(r);
         ph += step_reg;
      end
      if (frame_outs.size() > 0) frame_outs[frame_outs.size()-1].last = 1'b1;
      phase_acc = (ph >= UNIT_PHASE) ? ph - UNIT_PHASE : 0;
      prev_smp = cur;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic push_frame(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_ch0 <= s0;
      req_sample_ch1 <= s1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      resample_frame(s0, s1);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_STEP_SIZE) step_reg = val[STEP_W-1:0];
      else act_reg = val[ACT_W-1:0];
   endtask

   // frames with no output may still be queued once results are all in
   task automatic settle();
      req_valid <= 1'b0;
      while (due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 35);
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_samples.size() == 0) begin
            $error("unexpected transfer: out_ch0=%0d out_ch1=%0d last_of_run=%0b",
                   $signed(rsp_out_ch0), $signed(rsp_out_ch1), rsp_last_of_run);
            fail_count++;
         end else begin
            got = due_samples.pop_front();
            if (rsp_out_ch0 !== got.ch0) begin
               $error("out_ch0: expected %0d, got %0d", $signed(got.ch0), $signed(rsp_out_ch0));
               fail_count++;
            end
            if (rsp_out_ch1 !== got.ch1) begin
               $error("out_ch1: expected %0d, got %0d", $signed(got.ch1), $signed(rsp_out_ch1));
               fail_count++;
            end
            if (rsp_last_of_run !== got.last) begin
               $error("last_of_run: expected %0b, got %0b", got.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("linear_interp_resampler_tb: done, errors");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] step_pick;
      interp_out_type        lit;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_WRITE: begin
               settle();
               write_reg(plan[i].idx, plan[i].data);
            end
            ROW_FRAME: begin
               push_frame(plan[i].a, plan[i].b);
               foreach (frame_outs[k]) due_samples.push_back(frame_outs[k]);
            end
            default: begin
               push_frame(plan[i].a, plan[i].b);
               if (plan[i].lit_hit) begin
                  lit = '{plan[i].e0, plan[i].e1, 1'b1};
                  due_samples.push_back(lit);
               end
            end
         endcase
      end

      for (int blk = 0; blk < BLOCKS; blk++) begin
         settle();
         steady = (blk == BLOCKS / 2);
         case ($urandom_range(9))
            0: step_pick = 20'd1024;
            1: step_pick = 20'hFFFFF;
            2: step_pick = CSR_DATA_W'($urandom_range(1023));
            3: step_pick = CSR_DATA_W'($urandom_range(20'hFFFFF));
            4, 5: step_pick = CSR_DATA_W'($urandom_range(65536, 16384));
            default: step_pick = CSR_DATA_W'($urandom_range(262144, 65536));
         endcase
         write_reg(CSR_STEP_SIZE, step_pick);
         write_reg(CSR_ACTIVE_CHANNELS, CSR_DATA_W'($urandom_range(3)));
         repeat (FRAMES_PER_BLOCK) begin
            push_frame(pick_sample(), pick_sample());
            foreach (frame_outs[k]) due_samples.push_back(frame_outs[k]);
         end
      end

      steady = 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("linear_interp_resampler_tb: done, clean");
      end else begin
         $display("linear_interp_resampler_tb: done, errors");
      end
      $finish;
   end

endmodule
